// ===== src/pfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants of the page frame replacement block.
// ----------------------------------------------------------------------------
package pfr_pkg;
	localparam int FRAMES_DEF    = 64;
	localparam int ADDR_BITS_DEF = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 7;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES      = 2'd2;

	localparam logic [1:0] POL_FIFO  = 2'd0;
	localparam logic [1:0] POL_LRU   = 2'd1;
	localparam logic [1:0] POL_CLOCK = 2'd2;
endpackage
`default_nettype wire

// ===== src/pfr_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_req_if
// Request channel: logical address and write flag.
// ----------------------------------------------------------------------------
interface pfr_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] logical_addr;
	logic        wr_ref;
	modport source (output valid, logical_addr, wr_ref, input ready);
	modport sink (input valid, logical_addr, wr_ref, output ready);
endinterface
`default_nettype wire

// ===== src/pfr_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_rsp_if
// Response channel: physical address, hit, write-back and counters.
// ----------------------------------------------------------------------------
interface pfr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] phys_addr;
	logic        hit;
	logic        wrote_back;
	logic [31:0] fault_count;
	logic [31:0] writeback_count;
	modport source (output valid, phys_addr, hit, wrote_back, fault_count,
		writeback_count, input ready);
	modport sink (input valid, phys_addr, hit, wrote_back, fault_count,
		writeback_count, output ready);
endinterface
`default_nettype wire

// ===== src/page_frame_replacement.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_replacement
// Inverted page table translation with fifo, lru and clock replacement.
// ----------------------------------------------------------------------------
// Usage: a request beat (logical_addr, wr_ref) on req is translated to
// one response beat on rsp. Configuration is written through cfg_we,
// cfg_idx, cfg_data while the block is idle.
// The frame table lives in one synchronous memory (page and stamp per
// frame, registered read); valid, dirty and referenced bits are
// flip-flops cleared at reset. The load queue is a second memory.
// Steps per beat: a lookup walk over the managed frames, one frame per
// cycle; on a miss a free search over the valid bits, then for lru a
// stamp walk, for clock a sweep over the referenced bits, for fifo a
// queue read; then a write step. The lookup and stamp walks read one
// frame at a time through the single read port of the frame memory.
// Only one beat is in flight; req.ready is high only when the block is
// idle and the output register is empty, so a new beat is not taken
// before the last response has left. A stalled response holds in the
// output register. Reset empties the table, queue and counters; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module page_frame_replacement
	import pfr_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	pfr_req_if.sink                    req,
	pfr_rsp_if.source                  rsp
);
	localparam int FW = $clog2(FRAMES);
	localparam int CW = $clog2(FRAMES + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_FREE = 3'd2;
	localparam logic [2:0] ST_LRU  = 3'd3;
	localparam logic [2:0] ST_CLK  = 3'd4;
	localparam logic [2:0] ST_FIFO = 3'd5;
	localparam logic [2:0] ST_UPD  = 3'd6;

	// configuration
	logic [1:0] policy_q;
	logic [4:0] shift_q;
	logic [6:0] fiu_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
			shift_q  <= 5'd12;
			fiu_q    <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POLICY:      policy_q <= cfg_data[1:0];
				REG_FRAME_SHIFT: shift_q  <= cfg_data[4:0];
				REG_FRAMES:      fiu_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// managed frame count
	logic [CW-1:0] n;
	always_comb begin
		if (fiu_q == 7'd0) n = CW'(1);
		else if (32'(fiu_q) > 32'(FRAMES)) n = CW'(FRAMES);
		else n = CW'(fiu_q);
	end

	// status bits
	logic [FRAMES-1:0] valid_q, dirty_q, ref_q;

	logic [2:0]    st_q;
	logic [31:0]   page_q, off_q;
	logic          wr_q;
	logic [CW-1:0] idx_q;
	logic          rd_v_q;
	logic [FW-1:0] rd_idx_q;
	logic [FW-1:0] frame_q;
	logic          hit_q, wb_q, fifo_wait_q;
	logic [31:0]   best_stamp_q;
	logic [31:0]   use_q, faults_q, wbs_q;
	logic [FW-1:0] order_head_q, order_tail_q, sweep_q;
	logic [CW-1:0] order_count_q;
	logic          out_v_q;
	logic [31:0]   out_pa_q;

	// frame memory: page and stamp
	logic [31:0] page_mem [FRAMES];
	logic [31:0] stamp_mem [FRAMES];
	logic [FW-1:0] rd_addr;
	logic [31:0] rd_page, rd_stamp;
	logic mem_we;
	logic [FW-1:0] wr_addr;
	logic [31:0] wr_page, wr_stamp;
	logic wr_page_en;
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[wr_addr] <= wr_stamp;
			if (wr_page_en) page_mem[wr_addr] <= wr_page;
		end
		rd_page  <= page_mem[rd_addr];
		rd_stamp <= stamp_mem[rd_addr];
	end

	// load queue memory
	logic [FW-1:0] q_mem [FRAMES];
	logic q_we;
	logic [FW-1:0] q_head_data;
	always_ff @(posedge clk) begin
		if (q_we) q_mem[order_tail_q] <= wr_addr;
		q_head_data <= q_mem[order_head_q];
	end

	// input split
	logic [31:0] addr_in, page_in, off_in, mask_in;
	always_comb begin
		addr_in = req.logical_addr;
		if (ADDR_BITS < 32) addr_in = addr_in & ((32'd1 << ADDR_BITS) - 32'd1);
		mask_in = (32'd1 << shift_q) - 32'd1;
		page_in = addr_in >> shift_q;
		off_in  = addr_in & mask_in;
	end

	assign req.ready = (st_q == ST_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.phys_addr = out_pa_q;
	assign rsp.hit = hit_q;
	assign rsp.wrote_back = wb_q;
	assign rsp.fault_count = faults_q;
	assign rsp.writeback_count = wbs_q;

	// advance helper
	function automatic logic [FW-1:0] adv(input logic [FW-1:0] x, input logic [CW-1:0] m);
		logic [CW:0] s;
		s = (CW+1)'(x) + (CW+1)'(1);
		adv = (s >= (CW+1)'(m)) ? '0 : FW'(s);
	endfunction

	// read address steering; frame 0 is read while idle
	logic last_idx;
	assign last_idx = (CW'(rd_idx_q) + CW'(1) >= n);
	always_comb begin
		rd_addr = idx_q[FW-1:0];
		if (st_q == ST_IDLE) rd_addr = '0;
		mem_we = 1'b0;
		wr_page_en = 1'b0;
		wr_addr = frame_q;
		wr_page = page_q;
		wr_stamp = use_q;
		q_we = 1'b0;
		if (st_q == ST_UPD) begin
			mem_we = 1'b1;
			wr_page_en = !hit_q;
			q_we = !hit_q && (policy_q != POL_LRU) && (policy_q != POL_CLOCK);
		end
	end

	logic [FW-1:0] free_idx;
	logic          free_any;
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (CW'(i) < n && !valid_q[i]) begin
				free_idx = FW'(i);
				free_any = 1'b1;
			end
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			page_q <= '0;
			off_q <= '0;
			wr_q <= 1'b0;
			idx_q <= '0;
			rd_v_q <= 1'b0;
			rd_idx_q <= '0;
			frame_q <= '0;
			hit_q <= 1'b0;
			wb_q <= 1'b0;
			fifo_wait_q <= 1'b0;
			best_stamp_q <= '0;
			valid_q <= '0;
			dirty_q <= '0;
			ref_q <= '0;
			use_q <= '0;
			faults_q <= '0;
			wbs_q <= '0;
			order_head_q <= '0;
			order_tail_q <= '0;
			order_count_q <= '0;
			sweep_q <= '0;
			out_v_q <= 1'b0;
			out_pa_q <= '0;
		end else begin
			if (out_v_q && rsp.ready) out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						page_q <= page_in;
						off_q <= off_in;
						wr_q <= req.wr_ref;
						idx_q <= CW'(1);
						rd_v_q <= 1'b1;
						rd_idx_q <= '0;
						hit_q <= 1'b0;
						wb_q <= 1'b0;
						st_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					// compare the entry read last cycle
					if (rd_v_q && valid_q[rd_idx_q] && rd_page == page_q) begin
						hit_q <= 1'b1;
						frame_q <= rd_idx_q;
						if (wr_q) dirty_q[rd_idx_q] <= 1'b1;
						ref_q[rd_idx_q] <= 1'b1;
						rd_v_q <= 1'b0;
						st_q <= ST_UPD;
					end else if (!rd_v_q) begin
						faults_q <= faults_q + 32'd1;
						st_q <= ST_FREE;
					end else begin
						rd_idx_q <= idx_q[FW-1:0];
						rd_v_q <= (idx_q < n);
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_FREE: begin
					if (free_any) begin
						frame_q <= free_idx;
						st_q <= ST_UPD;
					end else if (policy_q == POL_LRU) begin
						idx_q <= '0;
						rd_v_q <= 1'b0;
						st_q <= ST_LRU;
					end else if (policy_q == POL_CLOCK) begin
						if (CW'(sweep_q) >= n) sweep_q <= '0;
						st_q <= ST_CLK;
					end else begin
						fifo_wait_q <= 1'b1;
						st_q <= ST_FIFO;
					end
				end
				ST_LRU: begin
					// walk stamps, keep the smallest, lowest frame on tie
					if (rd_v_q) begin
						if (rd_idx_q == '0 || rd_stamp < best_stamp_q) begin
							best_stamp_q <= rd_stamp;
							frame_q <= rd_idx_q;
						end
						if (last_idx) st_q <= ST_UPD;
					end
					if (idx_q < n) begin
						rd_idx_q <= idx_q[FW-1:0];
						rd_v_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
					end else begin
						rd_v_q <= 1'b0;
					end
				end
				ST_CLK: begin
					sweep_q <= adv(sweep_q, n);
					if (!ref_q[sweep_q]) begin
						frame_q <= sweep_q;
						st_q <= ST_UPD;
					end else begin
						ref_q[sweep_q] <= 1'b0;
					end
				end
				ST_FIFO: begin
					// wait once on entry for the registered queue head data
					if (fifo_wait_q) begin
						fifo_wait_q <= 1'b0;
					end else begin
						if (order_count_q != '0) begin
							frame_q <= (CW'(q_head_data) >= n) ? '0 : q_head_data;
							order_head_q <= adv(order_head_q, n);
							order_count_q <= order_count_q - CW'(1);
						end else begin
							frame_q <= '0;
						end
						st_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					use_q <= use_q + 32'd1;
					if (!hit_q) begin
						if (valid_q[frame_q] && dirty_q[frame_q]) begin
							wb_q <= 1'b1;
							wbs_q <= wbs_q + 32'd1;
						end
						valid_q[frame_q] <= 1'b1;
						dirty_q[frame_q] <= wr_q;
						ref_q[frame_q] <= 1'b1;
						if (q_we) begin
							order_tail_q <= adv(order_tail_q, n);
							if (order_count_q < n) order_count_q <= order_count_q + CW'(1);
						end
					end
					out_pa_q <= (32'(frame_q) << shift_q) | off_q;
					out_v_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== verif/page_frame_replacement_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_replacement_chk
// Watches the request, response and register ports of the frame table,
// tracks its own copy of the table and counters, and compares every
// response beat field by field against the predicted translation.
// ----------------------------------------------------------------------------
module page_frame_replacement_chk
	import pfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	pfr_req_if                         req,
	pfr_rsp_if                         rsp,
	output int                         errors,
	output int                         outstanding
);
	localparam int NF = FRAMES_DEF;

	typedef struct packed {
		logic [31:0] phys_addr;
		logic        hit;
		logic        wrote_back;
		logic [31:0] fault_count;
		logic [31:0] writeback_count;
	} xlat_t;

	xlat_t xlat_q[$];

	// shadow of the frame table and counters
	logic [31:0] tbl_page[NF];
	bit          tbl_valid[NF];
	bit          tbl_dirty[NF];
	bit          tbl_ref[NF];
	logic [31:0] tbl_stamp[NF];
	logic [5:0]  fifo_slot[NF];
	logic [31:0] use_tick;
	int          order_rd, order_wr, fifo_fill, hand;
	logic [31:0] faults, wbacks;
	logic [1:0]  cur_policy;
	logic [4:0]  cur_shift;
	logic [6:0]  cur_frames;

	function automatic int wrap_inc(int x, int n);
		return (x + 1 >= n) ? 0 : x + 1;
	endfunction

	// translate one reference and update the shadow table
	task automatic translate(input logic [31:0] addr, input bit wr, output xlat_t res);
		int          n;
		int          frame;
		bit          hit;
		bit          found;
		bit          wb;
		logic [31:0] page;
		logic [63:0] offset;
		logic [63:0] pa;
		n = (cur_frames == 0) ? 1 : ((cur_frames > NF) ? NF : int'(cur_frames));
		page = addr >> cur_shift;
		offset = {32'd0, addr} & ((64'd1 << cur_shift) - 64'd1);
		frame = 0;
		hit = 0;
		found = 0;
		wb = 0;
		for (int i = 0; i < n; i++) begin
			if (tbl_valid[i] && tbl_page[i] == page) begin
				if (wr)
					tbl_dirty[i] = 1;
				tbl_ref[i] = 1;
				tbl_stamp[i] = use_tick;
				use_tick++;
				frame = i;
				hit = 1;
				break;
			end
		end
		if (!hit) begin
			faults++;
			for (int i = 0; i < n; i++) begin
				if (!tbl_valid[i]) begin
					frame = i;
					found = 1;
					break;
				end
			end
			if (!found) begin
				// victim choice
				if (cur_policy == POL_LRU) begin
					for (int i = 1; i < n; i++)
						if (tbl_stamp[i] < tbl_stamp[frame])
							frame = i;
				end else if (cur_policy == POL_CLOCK) begin
					if (hand >= n)
						hand = 0;
					forever begin
						int p;
						p = hand;
						hand = wrap_inc(p, n);
						if (!tbl_ref[p]) begin
							frame = p;
							break;
						end
						tbl_ref[p] = 0;
					end
				end else if (fifo_fill != 0) begin
					frame = fifo_slot[order_rd % NF];
					order_rd = wrap_inc(order_rd, n);
					fifo_fill--;
					if (frame >= n)
						frame = 0;
				end
				if (tbl_valid[frame] && tbl_dirty[frame]) begin
					wb = 1;
					wbacks++;
				end
			end
			tbl_valid[frame] = 1;
			tbl_page[frame] = page;
			tbl_dirty[frame] = wr;
			tbl_ref[frame] = 1;
			tbl_stamp[frame] = use_tick;
			use_tick++;
			// load order kept only for fifo and the unused code
			if (cur_policy != POL_LRU && cur_policy != POL_CLOCK) begin
				fifo_slot[order_wr % NF] = frame[5:0];
				order_wr = wrap_inc(order_wr, n);
				if (fifo_fill < n)
					fifo_fill++;
			end
		end
		pa = (64'(frame) << cur_shift) | offset;
		res.phys_addr = pa[31:0];
		res.hit = hit;
		res.wrote_back = wb;
		res.fault_count = faults;
		res.writeback_count = wbacks;
	endtask

	always @(posedge clk or negedge arst_n) begin
		xlat_t got;
		xlat_t want;
		xlat_t pred;
		if (!arst_n) begin
			for (int i = 0; i < NF; i++) begin
				tbl_page[i] = '0;
				tbl_valid[i] = 0;
				tbl_dirty[i] = 0;
				tbl_ref[i] = 0;
				tbl_stamp[i] = '0;
				fifo_slot[i] = '0;
			end
			use_tick = '0;
			order_rd = 0;
			order_wr = 0;
			fifo_fill = 0;
			hand = 0;
			faults = '0;
			wbacks = '0;
			cur_policy = POL_FIFO;
			cur_shift = 5'd12;
			cur_frames = 7'd64;
			xlat_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_idx)
					REG_POLICY: cur_policy = cfg_data[1:0];
					REG_FRAME_SHIFT: cur_shift = cfg_data[4:0];
					REG_FRAMES: cur_frames = cfg_data[6:0];
					default: ;
				endcase
			end
			// response beat
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.phys_addr, rsp.hit, rsp.wrote_back, rsp.fault_count,
					rsp.writeback_count};
				if (xlat_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response beat: %p", got);
				end else begin
					want = xlat_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			// request beat
			if (req.valid && req.ready) begin
				translate(req.logical_addr, req.wr_ref, pred);
				xlat_q.push_back(pred);
			end
			outstanding = xlat_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== verif/page_frame_replacement_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_replacement_tb
// Drives references through the frame table under every replacement
// policy and a range of frame sizes and frame counts, with random gaps
// and response stalls; the checker beside the block scores each beat.
// ----------------------------------------------------------------------------
module page_frame_replacement_tb;
	import pfr_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    outstanding;
	int                    cycles;
	bit                    quiet;
	int                    stall_left;

	pfr_req_if req ();
	pfr_rsp_if rsp ();

	page_frame_replacement uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req), .rsp(rsp)
	);

	page_frame_replacement_chk chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req), .rsp(rsp), .errors(errors),
		.outstanding(outstanding)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[page_frame_replacement] ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// response stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
			stall_left <= 0;
		end else if (quiet) begin
			rsp.ready <= 1;
		end else if (stall_left > 0) begin
			rsp.ready <= 0;
			stall_left <= stall_left - 1;
		end else begin
			int r;
			r = $urandom_range(0, 99);
			rsp.ready <= (r < 70);
			if (r >= 70)
				stall_left <= (r < 92) ? $urandom_range(0, 3) : $urandom_range(10, 40);
		end
	end

	// one request beat, held until accepted
	task automatic send(input logic [31:0] addr, input bit wr);
		int g;
		g = pick_gap();
		if (g > 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1;
		req.logical_addr <= addr;
		req.wr_ref <= wr;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain();
		req.valid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// references drawn from a small page pool for locality, some noise
	task automatic run_phase(input logic [1:0] pol, input int sh, input int nfr, input int cnt);
		int          pool;
		logic [31:0] base;
		logic [63:0] maxpage;
		logic [63:0] page;
		logic [63:0] a;
		drain();
		write_reg(REG_POLICY, CFG_DATA_W'(pol));
		write_reg(REG_FRAME_SHIFT, CFG_DATA_W'(sh));
		write_reg(REG_FRAMES, CFG_DATA_W'(nfr));
		quiet = ($urandom_range(0, 3) == 0);
		pool = ((nfr == 0) ? 1 : ((nfr > 64) ? 64 : nfr)) * 3 / 2 + 2;
		maxpage = (64'd1 << (32 - sh)) - 1;
		base = $urandom;
		for (int i = 0; i < cnt; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				send($urandom, 1'($urandom_range(0, 1)));
			end else begin
				page = (64'(base) + $urandom_range(0, pool - 1)) & maxpage;
				a = (page << sh) | (64'($urandom) & ((64'd1 << sh) - 1));
				send(a[31:0], 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = REG_POLICY;
		cfg_data = '0;
		req.valid = 0;
		req.logical_addr = '0;
		req.wr_ref = 0;
		cycles = 0;
		quiet = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// fill every frame under fifo so each load order slot gets written
		write_reg(REG_POLICY, CFG_DATA_W'(POL_FIFO));
		write_reg(REG_FRAMES, 7'd64);
		write_reg(REG_FRAME_SHIFT, 7'd12);
		for (int i = 0; i < 64; i++)
			send((32'd1000 + i) << 12 | 32'($urandom_range(0, 4095)), i[0]);

		// directed: address extremes, hits, dirty evictions
		send(32'h0000_0000, 0);
		send(32'hFFFF_FFFF, 1);
		send(32'h003E_8FFF, 1);
		send(32'h003E_8000, 0);
		send(32'h0000_0FFF, 1);
		send(32'h8000_0000, 0);
		send(32'hFFFF_F000, 0);
		send(32'h7FFF_FFFF, 1);
		drain();
		write_reg(REG_FRAME_SHIFT, 7'd0);
		send(32'hFFFF_FFFF, 1);
		send(32'h0000_0001, 0);
		drain();
		write_reg(REG_FRAME_SHIFT, 7'd31);
		send(32'h7FFF_FFFF, 0);
		send(32'hFFFF_FFFF, 1);

		// random phases over policies, frame sizes and frame counts
		run_phase(POL_LRU, 12, 8, 150);
		run_phase(POL_CLOCK, 4, 4, 150);
		run_phase(POL_FIFO, 8, 16, 150);
		run_phase(2'd3, 10, 5, 140);
		run_phase(POL_CLOCK, 24, 64, 170);
		run_phase(POL_LRU, 1, 1, 100);
		run_phase(POL_FIFO, 31, 2, 100);
		run_phase(POL_CLOCK, 0, 3, 140);
		run_phase(POL_LRU, 16, 127, 170);
		run_phase(POL_FIFO, 12, 0, 100);
		run_phase(POL_CLOCK, 6, 32, 150);
		run_phase(POL_LRU, 20, 12, 250);

		drain();
		repeat (250) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("[page_frame_replacement] OK");
		else
			$display("[page_frame_replacement] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
